### rtl/core/skvt_pkg.sv
// Shared types and constants for the small key/value table.
`default_nettype none

package skvt_pkg;

    // Table geometry.
    localparam int ENTRIES = 64;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int KEY_W   = 22;
    localparam int DATA_W  = 32;
    localparam int OP_W    = 2;
    localparam int ST_W    = 2;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_SET    = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    // Status codes.
    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_MISSING = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd2;

    // Input beat.
    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic [KEY_W-1:0]         key;
        logic signed [DATA_W-1:0] value;
    } t_in;

    // Output beat.
    typedef struct packed {
        logic                     found;
        logic signed [DATA_W-1:0] read_value;
        logic [ST_W-1:0]          status;
    } t_out;

endpackage

`default_nettype wire

### rtl/core/skvt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module skvt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                           i_wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                           o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

### rtl/core/small_key_value_table_unit.sv
// Key/value table: last-hit cache plus a one-slot-per-cycle scan over the key RAM, with a data RAM beside it.
// One item at a time. An unknown operation goes straight to the output step; a cache hit skips
// the key RAM scan; a found lookup adds a data RAM read step before the output step. The output
// register lets the next item start while its beat waits for the downstream side.
// Reset clears all slot valid bits and the last-hit cache; key and data RAMs are not cleared.
`default_nettype none

module small_key_value_table_unit (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire skvt_pkg::t_in i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output skvt_pkg::t_out     o_out_data
);

    localparam logic [skvt_pkg::IDX_W-1:0] LAST_IDX =
        skvt_pkg::IDX_W'(skvt_pkg::ENTRIES - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ACT,
        S_LOAD,
        S_OUT
    } t_state;

    t_state r_state;

    // Latched item.
    logic [skvt_pkg::OP_W-1:0]   r_op;
    logic [skvt_pkg::KEY_W-1:0]  r_key;
    logic [skvt_pkg::DATA_W-1:0] r_value;

    // Search results.
    logic                        r_found;
    logic [skvt_pkg::IDX_W-1:0]  r_idx;
    logic                        r_free_ok;
    logic                        r_free_vld;
    logic [skvt_pkg::IDX_W-1:0]  r_free_idx;

    // Scan pipeline: read address and the slot whose key arrives this cycle.
    logic [skvt_pkg::IDX_W-1:0]  r_addr;
    logic [skvt_pkg::IDX_W-1:0]  r_cmp_idx;
    logic                        r_cmp_vld;

    // Slot valid bits and last-hit cache.
    logic [skvt_pkg::ENTRIES-1:0] r_valid;
    logic [skvt_pkg::KEY_W-1:0]   r_hit_key;
    logic [skvt_pkg::IDX_W-1:0]   r_hit_index;
    logic                         r_hit_valid;

    skvt_pkg::t_out r_res;
    skvt_pkg::t_out r_out;
    logic           r_out_valid;

    // RAM ports.
    logic                        key_wr_en;
    logic                        data_wr_en;
    logic [skvt_pkg::KEY_W-1:0]  key_rdata;
    logic [skvt_pkg::DATA_W-1:0] data_rdata;

    // Scan compare terms.
    logic                        cur_match;
    logic                        cur_free;
    logic                        free_any;
    logic [skvt_pkg::IDX_W-1:0]  free_sel;
    logic                        cache_hit;
    logic                        out_load;

    assign cur_match = r_valid[r_cmp_idx] && (key_rdata == r_key);
    assign cur_free  = !r_valid[r_cmp_idx];
    assign free_any  = r_free_vld || cur_free;
    assign free_sel  = r_free_vld ? r_free_idx : r_cmp_idx;
    assign cache_hit = r_hit_valid && (r_hit_key == i_in_data.key);

    // The finished result moves into the output register once that register is free.
    assign out_load  = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    // A new key writes both RAMs; an existing key rewrites only the data.
    assign key_wr_en  = (r_state == S_ACT) && (r_op == skvt_pkg::OP_SET)
                        && !r_found && r_free_ok;
    assign data_wr_en = (r_state == S_ACT) && (r_op == skvt_pkg::OP_SET)
                        && (r_found || r_free_ok);

    skvt_ram #(
        .WIDTH (skvt_pkg::KEY_W),
        .DEPTH (skvt_pkg::ENTRIES)
    ) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   (key_wr_en),
        .i_wr_addr (r_idx),
        .i_wr_data (r_key),
        .i_rd_addr (r_addr),
        .o_rd_data (key_rdata)
    );

    skvt_ram #(
        .WIDTH (skvt_pkg::DATA_W),
        .DEPTH (skvt_pkg::ENTRIES)
    ) u_data_ram (
        .i_clk     (i_clk),
        .i_wr_en   (data_wr_en),
        .i_wr_addr (r_idx),
        .i_wr_data (r_value),
        .i_rd_addr (r_idx),
        .o_rd_data (data_rdata)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Sequencer, table state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_hit_key   <= '0;
            r_hit_index <= '0;
            r_hit_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_cmp_vld   <= 1'b0;
            r_free_vld  <= 1'b0;
        end else begin
            // Load a new beat, or let the downstream side take the waiting one.
            if (out_load) begin
                r_out       <= r_res;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op       <= i_in_data.operation;
                        r_key      <= i_in_data.key;
                        r_value    <= $unsigned(i_in_data.value);
                        r_addr     <= '0;
                        r_cmp_vld  <= 1'b0;
                        r_free_vld <= 1'b0;
                        if (i_in_data.operation != skvt_pkg::OP_SET
                                && i_in_data.operation != skvt_pkg::OP_LOOKUP
                                && i_in_data.operation != skvt_pkg::OP_REMOVE) begin
                            // Unknown operation: no state change, empty result.
                            r_res.found      <= 1'b0;
                            r_res.read_value <= '0;
                            r_res.status     <= skvt_pkg::ST_OK;
                            r_state          <= S_OUT;
                        end else if (cache_hit) begin
                            r_found <= 1'b1;
                            r_idx   <= r_hit_index;
                            r_state <= S_ACT;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end

                S_SCAN: begin
                    // Issue the next key read while comparing the previous one.
                    r_cmp_idx <= r_addr;
                    r_cmp_vld <= 1'b1;
                    if (r_addr != LAST_IDX) begin
                        r_addr <= r_addr + 1'b1;
                    end
                    if (r_cmp_vld) begin
                        if (cur_match) begin
                            r_found     <= 1'b1;
                            r_idx       <= r_cmp_idx;
                            r_hit_key   <= r_key;
                            r_hit_index <= r_cmp_idx;
                            r_hit_valid <= 1'b1;
                            r_state     <= S_ACT;
                        end else if (r_cmp_idx == LAST_IDX) begin
                            r_found   <= 1'b0;
                            r_free_ok <= free_any;
                            r_idx     <= free_sel;
                            r_state   <= S_ACT;
                        end else if (cur_free && !r_free_vld) begin
                            r_free_vld <= 1'b1;
                            r_free_idx <= r_cmp_idx;
                        end
                    end
                end

                S_ACT: begin
                    r_res.found      <= r_found;
                    r_res.read_value <= '0;
                    case (r_op)
                        skvt_pkg::OP_SET: begin
                            if (!r_found && r_free_ok) begin
                                r_valid[r_idx] <= 1'b1;
                            end
                            r_res.status <= (!r_found && !r_free_ok) ? skvt_pkg::ST_FULL
                                                                     : skvt_pkg::ST_OK;
                            r_state      <= S_OUT;
                        end
                        skvt_pkg::OP_LOOKUP: begin
                            // The data read of this slot lands next cycle.
                            r_res.status <= skvt_pkg::ST_OK;
                            r_state      <= r_found ? S_LOAD : S_OUT;
                        end
                        skvt_pkg::OP_REMOVE: begin
                            if (r_found) begin
                                r_valid[r_idx] <= 1'b0;
                                r_hit_valid    <= 1'b0;
                            end
                            r_res.status <= r_found ? skvt_pkg::ST_OK : skvt_pkg::ST_MISSING;
                            r_state      <= S_OUT;
                        end
                        default: begin
                            r_res.status <= skvt_pkg::ST_OK;
                            r_state      <= S_OUT;
                        end
                    endcase
                end

                S_LOAD: begin
                    r_res.read_value <= $signed(data_rdata);
                    r_state          <= S_OUT;
                end

                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### sim/tb.sv
// Self-checking testbench for the small key/value table unit.
`timescale 1ns / 1ps

module tb;
    import skvt_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int POOL_SIZE   = 80;
    localparam int PHASE_ITEMS = 550;

    localparam logic [OP_W-1:0]   OP_UNUSED = 2'd3;
    localparam logic [KEY_W-1:0]  KEY_MAX   = '1;
    localparam logic [DATA_W-1:0] DATA_MIN  = {1'b1, {(DATA_W - 1){1'b0}}};
    localparam logic [DATA_W-1:0] DATA_MAX  = {1'b0, {(DATA_W - 1){1'b1}}};

    // Mirror of the table contents; predicts one reply per accepted request beat.
    class pid_table_mirror;
        bit                slot_used[ENTRIES];
        logic [KEY_W-1:0]  slot_pid[ENTRIES];
        logic [DATA_W-1:0] slot_val[ENTRIES];
        logic [KEY_W-1:0]  last_pid;
        int                last_idx;
        bit                last_ok;
        t_out              expected_replies[$];
        int                mismatch_count;

        function new();
            foreach (slot_used[i]) slot_used[i] = 1'b0;
            last_pid       = '0;
            last_idx       = 0;
            last_ok        = 1'b0;
            mismatch_count = 0;
        endfunction

        // Last-hit cache first, then a scan from slot zero upward.
        function int find_pid(logic [KEY_W-1:0] pid);
            int i;
            if (last_ok && last_pid == pid) return last_idx;
            for (i = 0; i < ENTRIES; i++) begin
                if (slot_used[i] && slot_pid[i] == pid) begin
                    last_pid = pid;
                    last_idx = i;
                    last_ok  = 1'b1;
                    return i;
                end
            end
            return -1;
        endfunction

        function void note_request(t_in req);
            t_out reply;
            int   idx;
            int   i;
            reply = '0;
            reply.status = ST_OK;
            case (req.operation)
                OP_SET: begin
                    idx = find_pid(req.key);
                    if (idx >= 0) begin
                        reply.found   = 1'b1;
                        slot_val[idx] = req.value;
                    end else begin
                        // The new key goes into the lowest free slot.
                        for (i = 0; i < ENTRIES && idx < 0; i++) begin
                            if (!slot_used[i]) idx = i;
                        end
                        if (idx < 0) begin
                            reply.status = ST_FULL;
                        end else begin
                            slot_used[idx] = 1'b1;
                            slot_pid[idx]  = req.key;
                            slot_val[idx]  = req.value;
                        end
                    end
                end
                OP_LOOKUP: begin
                    idx = find_pid(req.key);
                    if (idx >= 0) begin
                        reply.found      = 1'b1;
                        reply.read_value = slot_val[idx];
                    end
                end
                OP_REMOVE: begin
                    idx = find_pid(req.key);
                    if (idx >= 0) begin
                        reply.found    = 1'b1;
                        slot_used[idx] = 1'b0;
                        last_ok        = 1'b0;
                    end else begin
                        reply.status = ST_MISSING;
                    end
                end
                default: begin
                end
            endcase
            expected_replies.push_back(reply);
        endfunction

        function void check_reply(t_out got);
            t_out want;
            if (expected_replies.size() == 0) begin
                $error("reply beat with no request outstanding: found %0d read_value %0d status %0d",
                       got.found, got.read_value, got.status);
                mismatch_count++;
                return;
            end
            want = expected_replies.pop_front();
            if (got.found !== want.found) begin
                $error("found: expected %0d, actual %0d", want.found, got.found);
                mismatch_count++;
            end
            if (got.read_value !== want.read_value) begin
                $error("read_value: expected %0d, actual %0d", want.read_value, got.read_value);
                mismatch_count++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                mismatch_count++;
            end
        endfunction

        function int pending();
            return expected_replies.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n   = 1'b0;
    logic in_valid  = 1'b0;
    t_in  in_data   = '0;
    logic out_stall = 1'b0;
    logic in_stall;
    logic out_valid;
    t_out out_data;

    pid_table_mirror  mirror = new();
    int               send_idle_pct  = 0;
    int               recv_stall_pct = 0;
    int               cycle_count    = 0;
    logic [KEY_W-1:0] pid_pool[POOL_SIZE];
    logic [KEY_W-1:0] last_key = '0;

    small_key_value_table_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("simulation failed");
        $finish;
    end

    // Beat monitor: replies are checked before the request beat of the same edge is noted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_valid && !out_stall) mirror.check_reply(out_data);
            if (in_valid && !in_stall) mirror.note_request(in_data);
        end
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    function automatic t_in make_beat(logic [OP_W-1:0] op, logic [KEY_W-1:0] pid,
                                      logic [DATA_W-1:0] val);
        t_in beat;
        beat.operation = op;
        beat.key       = pid;
        beat.value     = val;
        return beat;
    endfunction

    // Random request: mostly pool keys so the table fills and drains, some repeats
    // to exercise the last-hit cache, and a few arbitrary keys that mostly miss.
    function automatic t_in random_request(int set_pct, int remove_pct);
        int                r;
        logic [OP_W-1:0]   op;
        logic [KEY_W-1:0]  pid;
        logic [DATA_W-1:0] val;
        r = $urandom_range(99);
        if (r < set_pct) op = OP_SET;
        else if (r < set_pct + remove_pct) op = OP_REMOVE;
        else if (r < 97) op = OP_LOOKUP;
        else op = OP_UNUSED;
        r = $urandom_range(99);
        if (r < 25) pid = last_key;
        else if (r < 90) pid = pid_pool[$urandom_range(POOL_SIZE - 1)];
        else pid = KEY_W'($urandom);
        last_key = pid;
        case ($urandom_range(15))
            0: val = DATA_MIN;
            1: val = DATA_MAX;
            2: val = '0;
            3: val = '1;
            default: val = $urandom;
        endcase
        return make_beat(op, pid, val);
    endfunction

    // Present one request beat, with an optional idle gap ahead of it.
    task automatic send_request(input t_in req);
        int gap_max;
        gap_max = (send_idle_pct > 50) ? 12 : 3;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
    endtask

    // Hold off new requests until every outstanding reply has arrived.
    task automatic wait_for_replies();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (mirror.pending() != 0);
    endtask

    // Main stimulus.
    initial begin
        t_in directed[$];
        int  phase;
        int  n;

        pid_pool[0] = '0;
        pid_pool[1] = KEY_MAX;
        for (n = 2; n < POOL_SIZE; n++) pid_pool[n] = KEY_W'($urandom);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed beats: empty-table misses, extremes of key and value, update of a
        // present key, cache reuse, a removed key that must read as gone, a reused
        // slot, a double remove, and the unused operation code.
        directed.push_back(make_beat(OP_LOOKUP, '0, DATA_MAX));
        directed.push_back(make_beat(OP_REMOVE, '0, '0));
        directed.push_back(make_beat(OP_UNUSED, '0, DATA_MAX));
        directed.push_back(make_beat(OP_SET, '0, DATA_MIN));
        directed.push_back(make_beat(OP_SET, KEY_MAX, DATA_MAX));
        directed.push_back(make_beat(OP_LOOKUP, '0, '0));
        directed.push_back(make_beat(OP_LOOKUP, '0, '1));
        directed.push_back(make_beat(OP_LOOKUP, KEY_MAX, '0));
        directed.push_back(make_beat(OP_SET, '0, '1));
        directed.push_back(make_beat(OP_LOOKUP, '0, '0));
        directed.push_back(make_beat(OP_SET, 22'h155555, 32'h5555_5555));
        directed.push_back(make_beat(OP_SET, 22'h2AAAAA, 32'hAAAA_AAAA));
        directed.push_back(make_beat(OP_LOOKUP, 22'h2AAAAA, '0));
        directed.push_back(make_beat(OP_REMOVE, '0, '0));
        directed.push_back(make_beat(OP_LOOKUP, '0, '0));
        directed.push_back(make_beat(OP_SET, 22'h123456, 32'h1234_5678));
        directed.push_back(make_beat(OP_LOOKUP, 22'h123456, '0));
        directed.push_back(make_beat(OP_REMOVE, KEY_MAX, '0));
        directed.push_back(make_beat(OP_REMOVE, KEY_MAX, '0));
        directed.push_back(make_beat(OP_LOOKUP, KEY_MAX, '0));
        directed.push_back(make_beat(OP_UNUSED, KEY_MAX, '1));
        directed.push_back(make_beat(OP_SET, 22'h155555, '0));
        directed.push_back(make_beat(OP_LOOKUP, 22'h155555, DATA_MIN));

        send_idle_pct  = 18;
        recv_stall_pct = 87;
        foreach (directed[i]) send_request(directed[i]);
        wait_for_replies();

        // Random phases: set-heavy to fill the table, then remove-heavy to drain it.
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 18;
                    recv_stall_pct = 87;
                end
                1: begin
                    send_idle_pct  = 87;
                    recv_stall_pct = 18;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (n < PHASE_ITEMS * 11 / 20) send_request(random_request(60, 10));
                else send_request(random_request(20, 50));
            end
            wait_for_replies();
        end

        // Let any stray reply show up before the verdict.
        repeat (ENTRIES + 10) @(posedge i_clk);
        if (mirror.pending() != 0) begin
            $error("%0d replies never arrived", mirror.pending());
            mirror.mismatch_count++;
        end

        if (mirror.mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/skvt_pkg.sv
rtl/core/skvt_ram.sv
rtl/core/small_key_value_table_unit.sv
sim/tb.sv
